/* src/secu_pkg.sv */
package secu_pkg;

	// Widths of the configuration registers and the state.
	localparam int unsigned CountW   = 8;
	localparam int unsigned DelayW   = 20;
	localparam int unsigned LockW    = 16;
	localparam int unsigned ActW     = 2;
	localparam int unsigned KindW    = 2;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 20;

	// Saturation value of the time since the last accepted edge.
	localparam logic [LockW-1:0] LockSat = '1;

	// Item kinds carried on the input tuser.
	localparam logic [KindW-1:0] KIND_TICK   = 2'd0;
	localparam logic [KindW-1:0] KIND_ARM    = 2'd1;
	localparam logic [KindW-1:0] KIND_DISARM = 2'd2;

	// Action codes.
	localparam logic [ActW-1:0] ACT_NONE  = 2'd0;
	localparam logic [ActW-1:0] ACT_BRAKE = 2'd1;
	localparam logic [ActW-1:0] ACT_COIL1 = 2'd2;
	localparam logic [ActW-1:0] ACT_COIL2 = 2'd3;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_START_LEVEL   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_EDGE_COUNT    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DELAY_TICKS   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ACTION        = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LOCKOUT_TICKS = 3'd4;

	// One result word.
	typedef struct packed {
		logic [CountW-1:0] remaining_edges;
		logic              armed;
		logic              fault;
		logic              done_res;
		logic              coil2_on;
		logic              coil1_on;
		logic              brake_on;
	} result_t;

endpackage

/* src/secu_out_buf.sv */
module secu_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  secu_pkg::result_t push_data,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output secu_pkg::result_t out_data
);
	import secu_pkg::*;

	// Two-entry shift queue; entry 0 is the head shown on the output.
	result_t    ent0_q;
	result_t    ent1_q;
	logic [1:0] count_q;
	logic       pop;
	logic [1:0] wpos;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign out_data  = ent0_q;
	// Room depends on the count only, so no ready path runs through the block.
	assign room      = (count_q != 2'd2);
	assign wpos      = count_q - {1'b0, pop};

	// Control: the fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Payload: shift on a pop, then write the new word behind the rest.
	always_ff @(posedge clk) begin
		if (pop) begin
			ent0_q <= ent1_q;
		end
		if (push) begin
			if (wpos == 2'd0) begin
				ent0_q <= push_data;
			end else begin
				ent1_q <= push_data;
			end
		end
	end

endmodule

/* src/shutter_edge_count_sequencer_unit.sv */
// Each word passes the input register and the two-entry result queue to m_tdata.
// Throughput: one word per cycle while the queue has room; the sequencer state is updated
// by one pass of logic from the input register, and the queue absorbs output stalls.
// Reset: arst_n is asynchronous and active low; it restores the register defaults
// (start level 1, edge count 1, delay 0, no action, lockout 2000) and clears the state,
// with the time since the last edge saturated. No clearing pass is needed.
module shutter_edge_count_sequencer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,  // [0] pi_level, [7:1] zero
	input  logic [secu_pkg::KindW-1:0]         s_tuser,  // [1:0] kind
	// Result stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] brake_on, [1] coil1_on, [2] coil2_on, [3] done_res, [4] fault, [5] armed,
	// [13:6] remaining_edges, [15:14] zero
	output logic [15:0]                        m_tdata,
	// Configuration writes.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [secu_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [secu_pkg::CfgDataW-1:0]      cfg_data
);
	import secu_pkg::*;

	// Configuration registers.
	logic              start_level_q;
	logic [CountW-1:0] edge_count_q;
	logic [DelayW-1:0] delay_ticks_q;
	logic [ActW-1:0]   action_q;
	logic [LockW-1:0]  lockout_q;

	// Sequencer state.
	logic              armed_q;
	logic              awaited_q;
	logic [CountW-1:0] remaining_q;
	logic [LockW-1:0]  since_q;
	logic              prev_level_q;
	logic              delay_run_q;
	logic [DelayW-1:0] delay_left_q;
	logic [ActW-1:0]   pending_q;

	// Input stage.
	logic             valid_s1;
	logic [KindW-1:0] kind_s1;
	logic             level_s1;

	logic    room;
	logic    advance;
	result_t res;
	result_t out_word;

	// Next-state values of one pass.
	logic              armed_d;
	logic              awaited_d;
	logic [CountW-1:0] remaining_d;
	logic [LockW-1:0]  since_d;
	logic              prev_level_d;
	logic              delay_run_d;
	logic [DelayW-1:0] delay_left_d;
	logic [ActW-1:0]   pending_d;
	logic [LockW-1:0]  since_inc;
	logic [DelayW-1:0] left_dec;
	logic              is_edge;
	logic [CountW-1:0] rem_dec;
	logic              fire_delay;
	logic              fire_now;
	logic [ActW-1:0]   act_delay;
	logic [ActW-1:0]   act_now;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && room;
	assign s_tready  = !valid_s1 || advance;

	// Configuration write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= 1'b1;
			edge_count_q  <= CountW'(1);
			delay_ticks_q <= '0;
			action_q      <= ACT_NONE;
			lockout_q     <= LockW'(2000);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_LEVEL:   start_level_q <= cfg_data[0];
				REG_EDGE_COUNT:    edge_count_q  <= cfg_data[CountW-1:0];
				REG_DELAY_TICKS:   delay_ticks_q <= cfg_data[DelayW-1:0];
				REG_ACTION:        action_q      <= cfg_data[ActW-1:0];
				REG_LOCKOUT_TICKS: lockout_q     <= cfg_data[LockW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			level_s1 <= s_tdata[0];
		end
	end

	// Tick arithmetic shared by the pass below.
	assign since_inc = (since_q != LockSat) ? since_q + LockW'(1) : since_q;
	assign left_dec  = (delay_left_q != '0) ? delay_left_q - DelayW'(1) : delay_left_q;
	assign rem_dec   = remaining_q - CountW'(1);
	assign is_edge   = armed_q && (level_s1 == awaited_q) && (prev_level_q != awaited_q)
		&& (since_inc >= lockout_q);

	// One pass of the sequencer over the word in the input register.
	always_comb begin
		armed_d      = armed_q;
		awaited_d    = awaited_q;
		remaining_d  = remaining_q;
		since_d      = since_q;
		prev_level_d = prev_level_q;
		delay_run_d  = delay_run_q;
		delay_left_d = delay_left_q;
		pending_d    = pending_q;
		fire_delay   = 1'b0;
		fire_now     = 1'b0;
		act_delay    = pending_q;
		act_now      = action_q;
		res          = '0;
		case (kind_s1)
			KIND_TICK: begin
				since_d      = since_inc;
				prev_level_d = level_s1;
				// A running delay counts down and fires on reaching zero.
				if (delay_run_q) begin
					delay_left_d = left_dec;
					if (left_dec == '0) begin
						delay_run_d = 1'b0;
						fire_delay  = 1'b1;
					end
				end
				// Qualified edge handling.
				if (is_edge) begin
					since_d = '0;
					if (remaining_q == '0) begin
						res.fault = 1'b1;
						armed_d   = 1'b0;
					end else begin
						remaining_d = rem_dec;
						if (rem_dec == '0) begin
							armed_d = 1'b0;
							if (delay_ticks_q != '0) begin
								delay_run_d  = 1'b1;
								delay_left_d = delay_ticks_q;
								pending_d    = action_q;
							end else begin
								fire_now = 1'b1;
							end
						end else begin
							awaited_d = !awaited_q;
						end
					end
				end
			end
			KIND_ARM: begin
				armed_d     = 1'b1;
				awaited_d   = start_level_q;
				remaining_d = edge_count_q;
			end
			KIND_DISARM: begin
				armed_d      = 1'b0;
				delay_run_d  = 1'b0;
				delay_left_d = '0;
			end
			default: begin
			end
		endcase
		// Both a delayed and an immediate action may fire on one tick.
		res.brake_on = (fire_delay && act_delay == ACT_BRAKE) || (fire_now && act_now == ACT_BRAKE);
		res.coil1_on = (fire_delay && act_delay == ACT_COIL1) || (fire_now && act_now == ACT_COIL1);
		res.coil2_on = (fire_delay && act_delay == ACT_COIL2) || (fire_now && act_now == ACT_COIL2);
		res.done_res        = fire_delay || fire_now;
		res.armed           = armed_d;
		res.remaining_edges = remaining_d;
	end

	// State registers update once per word that moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			awaited_q    <= 1'b0;
			remaining_q  <= '0;
			since_q      <= LockSat;
			prev_level_q <= 1'b0;
			delay_run_q  <= 1'b0;
			delay_left_q <= '0;
			pending_q    <= ACT_NONE;
		end else if (advance) begin
			armed_q      <= armed_d;
			awaited_q    <= awaited_d;
			remaining_q  <= remaining_d;
			since_q      <= since_d;
			prev_level_q <= prev_level_d;
			delay_run_q  <= delay_run_d;
			delay_left_q <= delay_left_d;
			pending_q    <= pending_d;
		end
	end

	// Result queue.
	secu_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_word)
	);

	assign m_tdata = {2'b00, out_word};

endmodule

/* src/secu_checker.sv */
module secu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Input only stalls when results are backed up.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// Any action pulse comes with the done flag.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[0] || m_tdata[1] || m_tdata[2]) |-> m_tdata[3])
		else $error("action fired without done");

	// A fault always leaves the block disarmed.
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[5])
		else $error("fault reported while still armed");

endmodule

bind shutter_edge_count_sequencer_unit secu_checker u_secu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
